@@ hdl/assert_macros.svh @@
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Check an implication in the following cycle.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

@@ hdl/psg_pkg.sv @@
// Types, constants and tables of the sound generator.
package psg_pkg;
   localparam int ClockRatio = 4;
   localparam int AccW = 9;

   localparam logic [2:0] ACT_LATCH   = 3'd0;
   localparam logic [2:0] ACT_WRITE   = 3'd1;
   localparam logic [2:0] ACT_READ    = 3'd2;
   localparam logic [2:0] ACT_ADVANCE = 3'd3;
   localparam logic [2:0] ACT_SAMPLE  = 3'd4;

   localparam logic [3:0] REG_NOISE = 4'd6;
   localparam logic [3:0] REG_MIXER = 4'd7;
   localparam logic [3:0] REG_ENV_FINE = 4'd11;
   localparam logic [3:0] REG_ENV_COARSE = 4'd12;
   localparam logic [3:0] REG_SHAPE = 4'd13;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_byte;
      logic [7:0] cycles;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  read_data;
      logic [15:0] left_sample;
      logic [15:0] right_sample;
   } rsp_type;

   function automatic logic [7:0] write_mask(input logic [3:0] a);
      logic [7:0] m;
      case (a)
         4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
         4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   // Envelope walk entry: low nibble level, bit 6 hold, bit 7 restart.
   function automatic logic [7:0] shape_walk(input logic [3:0] s, input logic [4:0] p);
      logic [7:0] e;
      logic [3:0] dn, up;
      dn = 4'd15 - p[3:0];
      up = p[3:0];
      e = 8'h00;
      case (s)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd9:
            e = (p < 5'd15) ? {4'h0, dn} : 8'h40;
         4'd4, 4'd5, 4'd6, 4'd7, 4'd15:
            e = (p < 5'd16) ? {4'h0, up} : 8'h40;
         4'd8:
            e = (p < 5'd15) ? {4'h0, dn} : 8'h80;
         4'd10:
            if (p < 5'd16) e = {4'h0, dn};
            else if (p < 5'd31) e = {4'h0, p[3:0]};
            else e = 8'h8F;
         4'd11:
            e = (p < 5'd16) ? {4'h0, dn} : 8'h4F;
         4'd12:
            e = (p < 5'd15) ? {4'h0, up} : 8'h8F;
         4'd13:
            e = (p < 5'd15) ? {4'h0, up} : 8'h4F;
         4'd14:
            if (p < 5'd16) e = {4'h0, up};
            else if (p < 5'd31) e = {4'h0, 4'd15 - p[3:0]};
            else e = 8'h80;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

   function automatic logic [14:0] dac_side(input logic [3:0] l);
      logic [14:0] v;
      case (l)
         4'd0: v = 15'd0;      4'd1: v = 15'd76;     4'd2: v = 15'd229;
         4'd3: v = 15'd381;    4'd4: v = 15'd687;    4'd5: v = 15'd916;
         4'd6: v = 15'd1374;   4'd7: v = 15'd2214;   4'd8: v = 15'd2672;
         4'd9: v = 15'd4352;   4'd10: v = 15'd6032;  4'd11: v = 15'd8018;
         4'd12: v = 15'd10614; 4'd13: v = 15'd13440; 4'd14: v = 15'd17410;
         default: v = 15'd21610;
      endcase
      return v;
   endfunction

   function automatic logic [13:0] dac_center(input logic [3:0] l);
      logic [13:0] v;
      case (l)
         4'd0: v = 14'd0;     4'd1: v = 14'd34;    4'd2: v = 14'd104;
         4'd3: v = 14'd173;   4'd4: v = 14'd313;   4'd5: v = 14'd417;
         4'd6: v = 14'd626;   4'd7: v = 14'd1009;  4'd8: v = 14'd1217;
         4'd9: v = 14'd1983;  4'd10: v = 14'd2748; 4'd11: v = 14'd3653;
         4'd12: v = 14'd4836; 4'd13: v = 14'd6123; 4'd14: v = 14'd7932;
         default: v = 14'd9845;
      endcase
      return v;
   endfunction
endpackage

@@ hdl/psg_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface psg_req_if;
   import psg_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface psg_rsp_if;
   import psg_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/three_channel_psg_sound_generator.sv @@
// Top level of the three-channel sound generator.
//  channel | dir | beat
//  req     | in  | action, data_byte, cycles
//  rsp     | out | kind, read_data, left_sample, right_sample
// Latch, write and read finish on the pop; a sample goes through mix and leak states.
// Advance ticks chip clocks while the accumulator holds a full ratio.
// A four-deep queue parts front and back; the response register frees on ready.
// Synchronous reset restores all state but queue storage and mix and response data.
module three_channel_psg_sound_generator (
   input logic clock,
   input logic reset,
   psg_req_if.sink   req,
   psg_rsp_if.source rsp
);
   import psg_pkg::*;
   req_type q_data;
   logic    q_valid, q_pop;

   psg_front u_front (.clock, .reset, .req, .q_data, .q_valid, .q_pop);
   psg_back  u_back (.clock, .reset, .q_data, .q_valid, .q_pop, .rsp);
endmodule

@@ hdl/psg_front.sv @@
// Front end: accepts request beats, drops action codes above sample, queues the rest.
module psg_front (
   input  logic               clock,
   input  logic               reset,
   psg_req_if.sink            req,
   output psg_pkg::req_type   q_data,
   output logic               q_valid,
   input  logic               q_pop
);
   import psg_pkg::*;

   localparam int Depth = 4;
   req_type    mem_ff [Depth];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       push, take, useful;

   assign req.ready = (cnt_ff != 3'(Depth));
   assign take = req.valid && req.ready;
   assign useful = (req.payload.action <= ACT_SAMPLE);
   assign push = take && useful;
   assign q_valid = (cnt_ff != 3'd0);
   assign q_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = q_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req.payload;
   end
endmodule

@@ hdl/psg_back.sv @@
// Back end: register file, chip clock walk, mixer and response register.
module psg_back (
   input  logic             clock,
   input  logic             reset,
   input  psg_pkg::req_type q_data,
   input  logic             q_valid,
   output logic             q_pop,
   psg_rsp_if.source        rsp
);
   import psg_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_MIX  = 2'd2;
   localparam logic [1:0] ST_LEAK = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic [7:0]  regs_ff [16];
   logic [3:0]  sel_ff;
   logic [AccW-1:0] acc_ff;
   logic [4:0]  epos_ff;
   logic [3:0]  elev_ff;
   logic [20:0] ecnt_ff;
   logic [2:0]  pre_ff;
   logic [5:0]  ncnt_ff;
   logic [17:0] lfsr_ff;
   logic        nbit_ff;
   logic [12:0] tcnt_ff [3];
   logic [2:0]  tbit_ff;
   logic [15:0] left_ff, right_ff;
   logic        out_v_ff;
   rsp_type     out_ff;

   logic        out_free, tick;
   logic [3:0]  lvl [3];
   logic [20:0] ecnt_dec;
   logic [7:0]  walk;
   logic [17:0] lfsr_nx;
   logic [4:0]  pos1;
   logic [15:0] l3, r3;

   assign out_free = !out_v_ff || rsp.ready;
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;
   assign tick = (acc_ff >= AccW'(ClockRatio));
   assign q_pop = q_valid && st_ff == ST_IDLE && out_free;

   assign ecnt_dec = ecnt_ff - 21'd1;
   assign walk = shape_walk(regs_ff[REG_SHAPE][3:0], epos_ff);
   assign pos1 = epos_ff + 5'd1;
   // Feedback adds at bit 16 on top of the shifted value; the sum may carry.
   assign lfsr_nx = {1'b0, lfsr_ff[17:1]} + ((lfsr_ff[2] ^ lfsr_ff[0]) ? 18'h10000 : 18'h0);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         lvl[c] = regs_ff[8+c][4] ? elev_ff : regs_ff[8+c][3:0];
         if (!regs_ff[REG_MIXER][3+c] && !nbit_ff) lvl[c] = 4'd0;
         if (!regs_ff[REG_MIXER][c] && !tbit_ff[c]) lvl[c] = 4'd0;
      end
      // x*3/100 as (x*3*167773)>>24, exact while 3x stays below 2^17
      l3 = 16'((64'({left_ff, 1'b0} + {1'b0, left_ff}) * 64'd167773) >> 24);
      r3 = 16'((64'({right_ff, 1'b0} + {1'b0, right_ff}) * 64'd167773) >> 24);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (q_pop) begin
            if (q_data.action == ACT_ADVANCE) st_in = ST_TICK;
            else if (q_data.action == ACT_SAMPLE) st_in = ST_MIX;
         end
         ST_TICK: if (!tick) st_in = ST_IDLE;
         ST_MIX: st_in = ST_LEAK;
         ST_LEAK: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         for (int i = 0; i < 16; i++) regs_ff[i] <= '0;
         sel_ff <= '0;
         acc_ff <= '0;
         epos_ff <= '0;
         elev_ff <= '0;
         ecnt_ff <= 21'd1;
         pre_ff <= 3'd7;
         ncnt_ff <= '0;
         lfsr_ff <= 18'h24000;
         nbit_ff <= 1'b0;
         for (int i = 0; i < 3; i++) tcnt_ff[i] <= '0;
         tbit_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if ((q_pop && q_data.action == ACT_READ) || (st_ff == ST_LEAK && out_free)) begin
            out_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
         if (q_pop) begin
            unique case (q_data.action)
               ACT_LATCH: if (q_data.data_byte < 8'd16) sel_ff <= q_data.data_byte[3:0];
               ACT_WRITE: begin
                  regs_ff[sel_ff] <= q_data.data_byte & write_mask(sel_ff);
                  if (sel_ff == REG_SHAPE) epos_ff <= '0;
               end
               ACT_READ: begin
                  out_ff <= '{kind: 1'b0, read_data: regs_ff[sel_ff],
                              left_sample: 16'd0, right_sample: 16'd0};
               end
               ACT_ADVANCE: acc_ff <= acc_ff + AccW'(q_data.cycles);
               default: ;
            endcase
         end
         // One chip clock per cycle while the accumulator holds a full ratio.
         if (st_ff == ST_TICK && tick) begin
            acc_ff <= acc_ff - AccW'(ClockRatio);
            pre_ff <= pre_ff + 3'd1;
            if (ecnt_dec == 21'd0) begin
               elev_ff <= walk[3:0];
               if (walk[7]) epos_ff <= '0;
               else if (!walk[6]) epos_ff <= pos1;
               ecnt_ff <= {({1'b0, regs_ff[REG_ENV_COARSE], regs_ff[REG_ENV_FINE]} + 17'd1),
                           4'b0};
            end else begin
               ecnt_ff <= ecnt_dec;
            end
            if (pre_ff == 3'd7) begin
               if (ncnt_ff + 6'd1 >= {1'b0, regs_ff[REG_NOISE][4:0]}) begin
                  lfsr_ff <= lfsr_nx;
                  if (!lfsr_nx[1]) nbit_ff <= !nbit_ff;
                  ncnt_ff <= '0;
               end else begin
                  ncnt_ff <= ncnt_ff + 6'd1;
               end
               for (int c = 0; c < 3; c++) begin
                  if (tcnt_ff[c] + 13'd1 >=
                      {1'b0, regs_ff[2*c+1][3:0], regs_ff[2*c]}) begin
                     tbit_ff[c] <= !tbit_ff[c];
                     tcnt_ff[c] <= '0;
                  end else begin
                     tcnt_ff[c] <= tcnt_ff[c] + 13'd1;
                  end
               end
            end
         end
         if (st_ff == ST_MIX) begin
            left_ff <= 16'(dac_side(lvl[0])) + 16'(dac_center(lvl[1]));
            right_ff <= 16'(dac_side(lvl[2])) + 16'(dac_center(lvl[1]));
         end
         if (st_ff == ST_LEAK && out_free) begin
            out_ff <= '{kind: 1'b1, read_data: 8'd0,
                        left_sample: left_ff + r3,
                        right_sample: right_ff + l3};
         end
      end
   end
endmodule

@@ hdl/psg_checker.sv @@
// Port checker for the sound generator and its bind.
`include "assert_macros.svh"
module psg_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input psg_pkg::rsp_type rsp_payload
);
   `CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHECK_IMPLY(a_read_zero, clock, reset, rsp_valid && !rsp_payload.kind,
      rsp_payload.left_sample == 16'd0 && rsp_payload.right_sample == 16'd0)
   `CHECK_IMPLY(a_smp_zero, clock, reset, rsp_valid && rsp_payload.kind,
      rsp_payload.read_data == 8'd0)
   `CHECK_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `CHECK_NEXT(a_reset_ready, clock, 1'b0, reset, req_ready)
endmodule

bind three_channel_psg_sound_generator psg_checker u_chk (
   .clock, .reset, .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));

@@ tb/psg_tb_checker.sv @@
`timescale 1ns / 100ps
// Predictor and scoreboard for the sound generator's request and response channels.
module psg_tb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input psg_pkg::req_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input psg_pkg::rsp_type rsp_payload,
   output int fail_count,
   output int pending_count,
   output int sample_count,
   output int read_count
);
   import psg_pkg::*;

   logic [7:0]  regs [16];
   logic [3:0]  sel;
   int unsigned acc;
   logic [4:0]  env_pos;
   logic [3:0]  env_lvl;
   logic [20:0] env_cnt;
   logic [2:0]  pre;
   logic [5:0]  noise_cnt;
   logic [17:0] lfsr;
   logic        noise_bit;
   logic [12:0] tone_cnt [3];
   logic        tone_bit [3];
   rsp_type     expected_q [$];

   function automatic logic [7:0] mask_of(input logic [3:0] a);
      case (a)
         4'd1, 4'd3, 4'd5, 4'd13: return 8'h0F;
         4'd6, 4'd8, 4'd9, 4'd10: return 8'h1F;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] walk_entry(input logic [3:0] s, input logic [4:0] p);
      int q;
      q = p;
      case (s)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd9: return (q < 15) ? 8'(15 - q) : 8'h40;
         4'd4, 4'd5, 4'd6, 4'd7, 4'd15: return (q < 16) ? 8'(q) : 8'h40;
         4'd8: return (q < 15) ? 8'(15 - q) : 8'h80;
         4'd10: return (q < 16) ? 8'(15 - q) : (q < 31) ? 8'(q - 16) : 8'h8F;
         4'd11: return (q < 16) ? 8'(15 - q) : 8'h4F;
         4'd12: return (q < 15) ? 8'(q) : 8'h8F;
         4'd13: return (q < 15) ? 8'(q) : 8'h4F;
         default: return (q < 16) ? 8'(q) : (q < 31) ? 8'(31 - q) : 8'h80;
      endcase
   endfunction

   function automatic int side_dac(input logic [3:0] l);
      int t [16] = '{0,76,229,381,687,916,1374,2214,2672,4352,6032,8018,10614,13440,
                     17410,21610};
      return t[l];
   endfunction

   function automatic int center_dac(input logic [3:0] l);
      int t [16] = '{0,34,104,173,313,417,626,1009,1217,1983,2748,3653,4836,6123,7932,
                     9845};
      return t[l];
   endfunction

   task automatic chip_tick();
      logic [7:0] e;
      int period;
      env_cnt = env_cnt - 21'd1;
      if (env_cnt == 0) begin
         e = walk_entry(regs[REG_SHAPE][3:0], env_pos);
         env_lvl = e[3:0];
         if (e[7] || e[6]) begin
            if (e[7]) env_pos = 0;
         end else begin
            env_pos = env_pos + 5'd1;
         end
         env_cnt = 21'((1 + regs[REG_ENV_FINE] + 256 * regs[REG_ENV_COARSE]) * 16);
      end
      pre = pre + 3'd1;
      if (pre != 0) return;
      noise_cnt = noise_cnt + 6'd1;
      if (noise_cnt >= regs[REG_NOISE]) begin
         lfsr = 18'(((lfsr[2] ^ lfsr[0]) ? 18'h10000 : 18'h0) + (lfsr >> 1));
         if (!lfsr[1]) noise_bit ^= 1'b1;
         noise_cnt = 0;
      end
      for (int i = 0; i < 3; i++) begin
         period = regs[2*i] + 256 * regs[2*i+1];
         tone_cnt[i] = tone_cnt[i] + 13'd1;
         if (tone_cnt[i] >= period) begin
            tone_bit[i] ^= 1'b1;
            tone_cnt[i] = 0;
         end
      end
   endtask

   function automatic logic [3:0] level_of(input int ch);
      logic [3:0] l;
      l = regs[8+ch][4] ? env_lvl : regs[8+ch][3:0];
      if (!regs[REG_MIXER][3+ch] && !noise_bit) l = 0;
      if (!regs[REG_MIXER][ch] && !tone_bit[ch]) l = 0;
      return l;
   endfunction

   task automatic predict(input req_type r);
      rsp_type o;
      int lsum, rsum;
      o = '0;
      case (r.action)
         ACT_LATCH: if (r.data_byte <= 15) sel = r.data_byte[3:0];
         ACT_WRITE: begin
            regs[sel] = r.data_byte & mask_of(sel);
            if (sel == REG_SHAPE) env_pos = 0;
         end
         ACT_READ: begin
            o.read_data = regs[sel];
            expected_q.push_back(o);
         end
         ACT_ADVANCE: begin
            acc += r.cycles;
            while (acc >= ClockRatio) begin
               acc -= ClockRatio;
               chip_tick();
            end
         end
         ACT_SAMPLE: begin
            lsum = side_dac(level_of(0)) + center_dac(level_of(1));
            rsum = side_dac(level_of(2)) + center_dac(level_of(1));
            o.kind = 1'b1;
            o.left_sample = 16'(lsum + rsum * 3 / 100);
            o.right_sample = 16'(rsum + lsum * 3 / 100);
            expected_q.push_back(o);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type x;
      if (reset) begin
         foreach (regs[i]) regs[i] = 0;
         sel = 0; acc = 0; env_pos = 0; env_lvl = 0; env_cnt = 1; pre = 7;
         noise_cnt = 0; lfsr = 18'h24000; noise_bit = 0;
         for (int i = 0; i < 3; i++) begin
            tone_cnt[i] = 0;
            tone_bit[i] = 0;
         end
         expected_q.delete();
         fail_count = 0; sample_count = 0; read_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               x = expected_q.pop_front();
               if (rsp_payload.kind !== x.kind) begin
                  $error("kind exp %0d got %0d", x.kind, rsp_payload.kind); fail_count++;
               end
               if (rsp_payload.read_data !== x.read_data) begin
                  $error("read_data exp %0d got %0d", x.read_data, rsp_payload.read_data);
                  fail_count++;
               end
               if (rsp_payload.left_sample !== x.left_sample) begin
                  $error("left_sample exp %0d got %0d", x.left_sample,
                         rsp_payload.left_sample);
                  fail_count++;
               end
               if (rsp_payload.right_sample !== x.right_sample) begin
                  $error("right_sample exp %0d got %0d", x.right_sample,
                         rsp_payload.right_sample);
                  fail_count++;
               end
               if (x.kind) sample_count++; else read_count++;
            end
         end
         if (req_valid && req_ready) predict(req_payload);
      end
      pending_count = expected_q.size();
   end
endmodule

@@ tb/three_channel_psg_sound_generator_tb.sv @@
`timescale 1ns / 100ps
// Stimulus, watchdog and verdict for the sound generator.
module three_channel_psg_sound_generator_tb;
   import psg_pkg::*;

   localparam int IdleLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, sample_count, read_count;
   int   idle_cycles = 0;
   int   beats_sent = 0;
   bit   hold_rsp = 1'b0;

   psg_req_if req ();
   psg_rsp_if rsp ();

   three_channel_psg_sound_generator u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source));

   psg_tb_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
      .fail_count(fail_count), .pending_count(pending_count),
      .sample_count(sample_count), .read_count(read_count));

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   // Send one beat, with a random gap first unless the stream is in a burst.
   // Valid stays high on return; the next gap or drain drops it.
   task automatic send(input logic [2:0] act, input logic [7:0] d, input logic [7:0] c,
                       input bit burst);
      int g;
      g = burst ? 0 : gap_len();
      repeat (g) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{action: act, data_byte: d, cycles: c};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [3:0] a, input logic [7:0] v);
      send(ACT_LATCH, {4'h0, a}, 8'($urandom), 1'b0);
      send(ACT_WRITE, v, 8'($urandom), 1'b0);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Receiver: random stalls, and a long hold-off as soon as it is asked for.
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               rsp.ready <= 1'b0;
               n = gap_len() + 1;
            end else begin
               rsp.ready <= 1'b1;
               n = $urandom_range(1, 20);
            end
            for (int k = 0; k < n && !hold_rsp; k++) @(negedge clock);
         end
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: no beat for %0d cycles", IdleLimit);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int r;
      req.valid = 1'b0;
      req.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: read-back of masked writes, latch out of range, unused actions, advance and sample.
      for (int a = 0; a < 16; a += 5) begin
         write_reg(a[3:0], 8'hFF);
         send(ACT_READ, 8'h00, 8'h00, 1'b0);
      end
      send(ACT_LATCH, 8'hFF, 8'h00, 1'b0);
      send(ACT_READ, 8'h00, 8'hFF, 1'b0);
      send(ACT_LATCH, 8'd16, 8'h00, 1'b0);
      send(3'd5, 8'hAA, 8'h55, 1'b0);
      send(3'd7, 8'h55, 8'hAA, 1'b0);
      write_reg(REG_MIXER, 8'h00);
      write_reg(REG_SHAPE, 8'h0E);
      send(ACT_ADVANCE, 8'h00, 8'hFF, 1'b0);
      send(ACT_SAMPLE, 8'hFF, 8'hFF, 1'b0);
      send(ACT_ADVANCE, 8'h00, 8'h00, 1'b0);
      send(ACT_SAMPLE, 8'h00, 8'h00, 1'b0);
      drain();

      // Pressure: hold the receiver off while reads keep coming.
      hold_rsp = 1'b1;
      repeat (12) send(ACT_READ, 8'h00, 8'h00, 1'b1);
      drain();

      // Random: mostly register setup, advances and samples.
      while (beats_sent < 430) begin
         r = $urandom_range(0, 99);
         if (r < 25) write_reg(4'($urandom), 8'($urandom));
         else if (r < 30) write_reg(4'($urandom_range(8, 10)), 8'($urandom_range(0, 31)));
         else if (r < 35) write_reg(4'($urandom_range(0, 6)), 8'($urandom_range(0, 3)));
         else if (r < 55) send(ACT_ADVANCE, 8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
         else if (r < 80) send(ACT_SAMPLE, 8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
         else if (r < 90) send(ACT_READ, 8'($urandom), 8'($urandom), 1'b0);
         else send(3'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end

      drain();
      repeat (100) @(negedge clock);
      $display("covered %0d request beats: %0d samples and %0d reads checked",
               beats_sent, sample_count, read_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ three_channel_psg_sound_generator.f @@
+incdir+hdl
hdl/psg_pkg.sv
hdl/psg_if.sv
hdl/psg_front.sv
hdl/psg_back.sv
hdl/three_channel_psg_sound_generator.sv
hdl/psg_checker.sv
tb/psg_tb_checker.sv
tb/three_channel_psg_sound_generator_tb.sv
